### hdl/m3i_pkg.sv
// Package: widths, payload types and pipeline constants for the 3x3 inverse core.
`timescale 1ns / 1ps
`default_nettype none
package m3i_pkg;
    localparam int ENT_W    = 32;              // Q16.16 entry
    localparam int PROD_W   = 2 * ENT_W;       // 2x2 product
    localparam int COF_W    = PROD_W + 1;      // exact cofactor, Q33.32
    localparam int DET_W    = 99;              // exact determinant, Q51.48
    localparam int NUM_W    = COF_W + ENT_W;   // |cofactor| * 2^32
    localparam int Q_W      = 34;              // quotient bits 33..0
    localparam int DSH_W    = DET_W + Q_W - 1; // divisor aligned to the top quotient bit
    localparam int N_LANE   = 9;
    localparam int FRONT_STG = 5;
    localparam int DIV_STG  = Q_W;
    localparam int N_STG    = FRONT_STG + DIV_STG + 1;

    localparam logic [ENT_W-1:0] SAT_POS = 32'h7FFF_FFFF;
    localparam logic [ENT_W-1:0] SAT_NEG = 32'h8000_0000;

    typedef struct packed {
        logic signed [ENT_W-1:0] a11;
        logic signed [ENT_W-1:0] a12;
        logic signed [ENT_W-1:0] a13;
        logic signed [ENT_W-1:0] a21;
        logic signed [ENT_W-1:0] a22;
        logic signed [ENT_W-1:0] a23;
        logic signed [ENT_W-1:0] a31;
        logic signed [ENT_W-1:0] a32;
        logic signed [ENT_W-1:0] a33;
    } m3i_in_t;

    typedef struct packed {
        logic signed [ENT_W-1:0] b11;
        logic signed [ENT_W-1:0] b12;
        logic signed [ENT_W-1:0] b13;
        logic signed [ENT_W-1:0] b21;
        logic signed [ENT_W-1:0] b22;
        logic signed [ENT_W-1:0] b23;
        logic signed [ENT_W-1:0] b31;
        logic signed [ENT_W-1:0] b32;
        logic signed [ENT_W-1:0] b33;
        logic                    singular;
    } m3i_out_t;

    // one item inside the divider pipeline
    typedef struct packed {
        logic [DSH_W-1:0]              dsh;
        logic [N_LANE-1:0][NUM_W-1:0]  rem;
        logic [N_LANE-1:0][Q_W-1:0]    quo;
        logic [N_LANE-1:0]             neg;
        logic                          singular;
    } m3i_div_t;

    // truncated quotient magnitude to signed 32 bits with saturation
    function automatic logic [ENT_W-1:0] m3i_sat(input logic [Q_W-1:0] q, input logic neg);
        logic [ENT_W-1:0] r;
        if (neg) begin
            if (q > {2'b00, SAT_NEG}) r = SAT_NEG;
            else r = ENT_W'(0) - q[ENT_W-1:0];
        end else begin
            if (q > {2'b00, SAT_POS}) r = SAT_POS;
            else r = q[ENT_W-1:0];
        end
        return r;
    endfunction
endpackage
`default_nettype wire

### hdl/m3i_front.sv
// Front pipeline: products, cofactors, determinant, magnitudes and signs.
`timescale 1ns / 1ps
`default_nettype none
module m3i_front
    import m3i_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic [FRONT_STG-1:0] en,
    input  wire m3i_in_t              in_data,
    output m3i_div_t                  out_data
);
    logic signed [ENT_W-1:0]  m [0:8];
    logic signed [PROD_W-1:0] prod_reg [0:8][0:1];
    logic signed [PROD_W-1:0] prod_next [0:8][0:1];
    logic signed [ENT_W-1:0]  row1_s1_reg [0:2];
    logic signed [ENT_W-1:0]  row1_s2_reg [0:2];
    logic signed [COF_W-1:0]  cof_s2_reg [0:8];
    logic signed [COF_W-1:0]  cof_s3_reg [0:8];
    logic signed [COF_W-1:0]  cof_s4_reg [0:8];
    logic signed [COF_W-1:0]  dp_lo_reg [0:2];
    logic signed [COF_W-1:0]  dp_hi_reg [0:2];
    logic signed [DET_W-1:0]  det_reg;
    logic signed [DET_W-1:0]  det_next;
    m3i_div_t                 out_reg;
    m3i_div_t                 out_next;

    always_comb begin
        m[0] = in_data.a11; m[1] = in_data.a12; m[2] = in_data.a13;
        m[3] = in_data.a21; m[4] = in_data.a22; m[5] = in_data.a23;
        m[6] = in_data.a31; m[7] = in_data.a32; m[8] = in_data.a33;
    end

    // cyclic cofactor rule
    always_comb begin
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                prod_next[r*3+c][0] = m[((r+1)%3)*3 + (c+1)%3] * m[((r+2)%3)*3 + (c+2)%3];
                prod_next[r*3+c][1] = m[((r+1)%3)*3 + (c+2)%3] * m[((r+2)%3)*3 + (c+1)%3];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            prod_reg <= prod_next;
            for (int c = 0; c < 3; c++) row1_s1_reg[c] <= m[c];
        end
        if (en[1]) begin
            for (int i = 0; i < 9; i++)
                cof_s2_reg[i] <= COF_W'(prod_reg[i][0]) - COF_W'(prod_reg[i][1]);
            row1_s2_reg <= row1_s1_reg;
        end
        if (en[2]) begin
            // 32 x 65 split into low unsigned and high signed halves
            for (int c = 0; c < 3; c++) begin
                dp_lo_reg[c] <= row1_s2_reg[c] * $signed({1'b0, cof_s2_reg[c][ENT_W-1:0]});
                dp_hi_reg[c] <= row1_s2_reg[c] * $signed(cof_s2_reg[c][COF_W-1:ENT_W]);
            end
            cof_s3_reg <= cof_s2_reg;
        end
        if (en[3]) begin
            det_reg    <= det_next;
            cof_s4_reg <= cof_s3_reg;
        end
        if (en[4]) out_reg <= out_next;
    end

    always_comb begin
        det_next = '0;
        for (int c = 0; c < 3; c++)
            det_next = det_next
                + {{2{dp_hi_reg[c][COF_W-1]}}, dp_hi_reg[c], {ENT_W{1'b0}}}
                + {{34{dp_lo_reg[c][COF_W-1]}}, dp_lo_reg[c]};
    end

    always_comb begin
        logic [DET_W-1:0] den_mag;
        logic [COF_W-1:0] num_mag;
        den_mag = det_reg[DET_W-1] ? DET_W'(-det_reg) : DET_W'(det_reg);
        out_next.dsh      = {den_mag, {(Q_W-1){1'b0}}};
        out_next.quo      = '0;
        out_next.singular = (det_reg == '0);
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                // inverse entry (r,c) takes the transposed cofactor
                num_mag = cof_s4_reg[c*3+r][COF_W-1] ? COF_W'(-cof_s4_reg[c*3+r])
                                                     : COF_W'(cof_s4_reg[c*3+r]);
                out_next.rem[r*3+c] = {num_mag, {ENT_W{1'b0}}};
                out_next.neg[r*3+c] = cof_s4_reg[c*3+r][COF_W-1] ^ det_reg[DET_W-1];
            end
        end
    end

    assign out_data = out_reg;
endmodule
`default_nettype wire

### hdl/m3i_div_stage.sv
// One restoring-division step for all nine lanes: one quotient bit per stage.
`timescale 1ns / 1ps
`default_nettype none
module m3i_div_stage
    import m3i_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     en,
    input  wire m3i_div_t in_data,
    output m3i_div_t      out_data
);
    m3i_div_t data_reg;
    m3i_div_t data_next;

    always_comb begin
        logic ge;
        data_next          = in_data;
        data_next.dsh      = in_data.dsh >> 1;
        for (int i = 0; i < N_LANE; i++) begin
            ge = {{(DSH_W-NUM_W){1'b0}}, in_data.rem[i]} >= in_data.dsh;
            // when ge, the shifted divisor fits in the remainder width
            if (ge) data_next.rem[i] = in_data.rem[i] - in_data.dsh[NUM_W-1:0];
            data_next.quo[i] = {in_data.quo[i][Q_W-2:0], ge};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) data_reg <= data_next;
    end

    assign out_data = data_reg;
endmodule
`default_nettype wire

### hdl/matrix3x3_inverse_core.sv
// Top level: pipelined 3x3 Q16.16 matrix inverse by adjugate over determinant.
//
//  port group   dir  beat content
//  s_*          in   m3i_in_t:  a11..a33, one matrix
//  m_*          out  m3i_out_t: b11..b33 inverse, singular flag
//
// One matrix per cycle while the output is not stalled; 5 front stages, 34 divider stages, output.
// The divider produces one quotient bit per stage for all nine lanes at once.
// Reset clears only the stage valid bits; no state carries between matrices.
// Each stage holds when the next one is full and stalled, so bubbles collapse
// and the input keeps taking beats while the output waits, until the pipe is full.
`timescale 1ns / 1ps
`default_nettype none
module matrix3x3_inverse_core
    import m3i_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_valid,
    output logic          s_ready,
    input  wire m3i_in_t  s_data,
    output logic          m_valid,
    input  wire logic     m_ready,
    output m3i_out_t      m_data
);
    logic [N_STG-1:0] vld_reg;
    logic [N_STG-1:0] vld_next;
    logic [N_STG:0]   adv;
    m3i_div_t         div_pipe [0:DIV_STG];
    m3i_out_t         out_reg;
    m3i_out_t         out_next;
    logic [ENT_W-1:0] b [0:N_LANE-1];

    always_comb begin
        adv[N_STG] = m_ready;
        for (int k = N_STG - 1; k >= 0; k--)
            adv[k] = ~vld_reg[k] | adv[k+1];
        for (int k = 0; k < N_STG; k++)
            vld_next[k] = adv[k] ? ((k == 0) ? s_valid : vld_reg[(k == 0) ? 0 : k-1])
                                 : vld_reg[k];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    m3i_front u_front (
        .aclk     (aclk),
        .en       (adv[FRONT_STG-1:0]),
        .in_data  (s_data),
        .out_data (div_pipe[0])
    );

    for (genvar g = 0; g < DIV_STG; g++) begin : g_div
        m3i_div_stage u_stage (
            .aclk     (aclk),
            .en       (adv[FRONT_STG+g]),
            .in_data  (div_pipe[g]),
            .out_data (div_pipe[g+1])
        );
    end

    always_comb begin
        for (int i = 0; i < N_LANE; i++)
            b[i] = div_pipe[DIV_STG].singular ? '0
                 : m3i_sat(div_pipe[DIV_STG].quo[i], div_pipe[DIV_STG].neg[i]);
        out_next.b11 = b[0]; out_next.b12 = b[1]; out_next.b13 = b[2];
        out_next.b21 = b[3]; out_next.b22 = b[4]; out_next.b23 = b[5];
        out_next.b31 = b[6]; out_next.b32 = b[7]; out_next.b33 = b[8];
        out_next.singular = div_pipe[DIV_STG].singular;
    end

    always_ff @(posedge aclk) begin
        if (adv[N_STG-1]) out_reg <= out_next;
    end

    assign s_ready = adv[0];
    assign m_valid = vld_reg[N_STG-1];
    assign m_data  = out_reg;
endmodule
`default_nettype wire

### hdl/m3i_checker.sv
// Port-level checks for the 3x3 inverse core, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module m3i_checker
    import m3i_pkg::*;
(
    input wire logic     aclk,
    input wire logic     aresetn,
    input wire logic     s_ready,
    input wire logic     m_valid,
    input wire logic     m_ready,
    input wire m3i_out_t m_data
);
    // a stalled result beat holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result beat changed while stalled");

    // a taken output frees the input side in the same cycle
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        m_ready |-> s_ready)
        else $error("input not ready while output drains");

    a_reset: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    a_sing: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.singular |->
            m_data.b11 == 0 && m_data.b12 == 0 && m_data.b13 == 0 &&
            m_data.b21 == 0 && m_data.b22 == 0 && m_data.b23 == 0 &&
            m_data.b31 == 0 && m_data.b32 == 0 && m_data.b33 == 0)
        else $error("singular result carries nonzero entries");
endmodule

bind matrix3x3_inverse_core m3i_checker u_m3i_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
`default_nettype wire
